// ----- design/cau_pkg.sv -----
// shared types, constants and helpers for the complex arithmetic unit
package cau_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH       = 2;    // power of two, pointers wrap
    localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int MUL_SLOTS         = 6;
    localparam int OPW               = 33;   // multiplier operand width
    localparam int PRODW             = 2 * OPW;
    localparam int SUMW              = PRODW + 1;
    localparam int ADDW              = 34;
    localparam int LW                = 68;   // working width of a result part
    localparam int QBITS             = 32;   // quotient bits below the cap
    localparam int DENW              = 64;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_MULCONJ = 4'd4,
        OP_CONJ    = 4'd5,
        OP_NEG     = 4'd6,
        OP_INV     = 4'd7,
        OP_ADDS    = 4'd8,
        OP_SUBS    = 4'd9,
        OP_MULS    = 4'd10,
        OP_DIVS    = 4'd11,
        OP_RSUB    = 4'd12,
        OP_RDIV    = 4'd13,
        OP_MIX     = 4'd14,
        OP_NORMSQ  = 4'd15
    } cau_kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } cau_status_t;

    typedef struct packed {
        cau_kind_t          kind;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic signed [31:0] scalar;
    } cau_in_t;

    typedef struct packed {
        logic signed [31:0] r_re;
        logic signed [31:0] r_im;
        cau_status_t        status;
    } cau_out_t;

    // classified request: slots 0/1 feed the real numerator, 2/3 the
    // imaginary one, 4/5 the divisor
    typedef struct packed {
        logic                            is_div;
        logic                            long_shift;
        logic [MUL_SLOTS-1:0][OPW-1:0]   ma;
        logic [MUL_SLOTS-1:0][OPW-1:0]   mb;
        logic signed [ADDW-1:0]          add_re;
        logic signed [ADDW-1:0]          add_im;
    } cau_op_t;

    typedef struct packed {
        logic                   is_div;
        logic                   divz;
        logic                   neg_re;
        logic                   neg_im;
        logic                   ov_re;
        logic                   ov_im;
        logic signed [LW-1:0]   lin_re;
        logic signed [LW-1:0]   lin_im;
    } cau_meta_t;

    localparam logic signed [LW-1:0] SAT_HI = LW'(2147483647);
    localparam logic signed [LW-1:0] SAT_LO = ~SAT_HI;

    // clamp to 32 bits, top bit flags a clamp
    function automatic logic [32:0] sat32(input logic signed [LW-1:0] v);
        logic [32:0] r;
        if (v > SAT_HI)
            r = {1'b1, SAT_HI[31:0]};
        else if (v < SAT_LO)
            r = {1'b1, SAT_LO[31:0]};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

// ----- design/cau_front.sv -----
// front end: decodes the operation and picks multiplier operands and linear terms
module cau_front (
    input  cau_pkg::cau_in_t req,
    output cau_pkg::cau_op_t op
);
    import cau_pkg::*;

    logic signed [OPW-1:0] xar, xai, xbr, xbi, xs, nar, nai, one;

    assign xar = OPW'(req.a_re);
    assign xai = OPW'(req.a_im);
    assign xbr = OPW'(req.b_re);
    assign xbi = OPW'(req.b_im);
    assign xs  = OPW'(req.scalar);
    assign nar = -xar;
    assign nai = -xai;
    assign one = OPW'(1);

    always_comb
    begin
        op = '0;
        unique case (req.kind)
            OP_ADD:
            begin
                op.add_re = ADDW'(xar) + ADDW'(xbr);
                op.add_im = ADDW'(xai) + ADDW'(xbi);
            end
            OP_SUB:
            begin
                op.add_re = ADDW'(xar) - ADDW'(xbr);
                op.add_im = ADDW'(xai) - ADDW'(xbi);
            end
            OP_MUL:
            begin
                op.ma[0] = xar; op.mb[0] = xbr;
                op.ma[1] = nai; op.mb[1] = xbi;
                op.ma[2] = xar; op.mb[2] = xbi;
                op.ma[3] = xai; op.mb[3] = xbr;
            end
            OP_DIV:
            begin
                op.is_div = 1'b1;
                op.ma[0] = xar; op.mb[0] = xbr;
                op.ma[1] = xai; op.mb[1] = xbi;
                op.ma[2] = xbr; op.mb[2] = xai;
                op.ma[3] = nar; op.mb[3] = xbi;
                op.ma[4] = xbr; op.mb[4] = xbr;
                op.ma[5] = xbi; op.mb[5] = xbi;
            end
            OP_MULCONJ:
            begin
                op.ma[0] = xar; op.mb[0] = xbr;
                op.ma[1] = xai; op.mb[1] = xbi;
                op.ma[2] = xai; op.mb[2] = xbr;
                op.ma[3] = nar; op.mb[3] = xbi;
            end
            OP_CONJ:
            begin
                op.add_re = ADDW'(xar);
                op.add_im = ADDW'(nai);
            end
            OP_NEG:
            begin
                op.add_re = ADDW'(nar);
                op.add_im = ADDW'(nai);
            end
            OP_INV:
            begin
                op.is_div     = 1'b1;
                op.long_shift = 1'b1;
                op.ma[0] = xar; op.mb[0] = one;
                op.ma[2] = nai; op.mb[2] = one;
                op.ma[4] = xar; op.mb[4] = xar;
                op.ma[5] = xai; op.mb[5] = xai;
            end
            OP_ADDS:
            begin
                op.add_re = ADDW'(xar) + ADDW'(xs);
                op.add_im = ADDW'(xai);
            end
            OP_SUBS:
            begin
                op.add_re = ADDW'(xar) - ADDW'(xs);
                op.add_im = ADDW'(xai);
            end
            OP_MULS:
            begin
                op.ma[0] = xar; op.mb[0] = xs;
                op.ma[2] = xai; op.mb[2] = xs;
            end
            OP_DIVS:
            begin
                op.is_div = 1'b1;
                op.ma[0] = xar; op.mb[0] = one;
                op.ma[2] = xai; op.mb[2] = one;
                op.ma[4] = xs;  op.mb[4] = one;
            end
            OP_RSUB:
            begin
                op.add_re = ADDW'(xs) - ADDW'(xar);
                op.add_im = ADDW'(nai);
            end
            OP_RDIV:
            begin
                op.is_div = 1'b1;
                op.ma[0] = xs;  op.mb[0] = xar;
                op.ma[2] = xs;  op.mb[2] = nai;
                op.ma[4] = xar; op.mb[4] = xar;
                op.ma[5] = xai; op.mb[5] = xai;
            end
            OP_MIX:
            begin
                // a + (b - a) * s
                op.ma[0] = xbr - xar; op.mb[0] = xs;
                op.ma[2] = xbi - xai; op.mb[2] = xs;
                op.add_re = ADDW'(xar);
                op.add_im = ADDW'(xai);
            end
            OP_NORMSQ:
            begin
                op.ma[0] = xar; op.mb[0] = xar;
                op.ma[1] = xai; op.mb[1] = xai;
            end
        endcase
    end

endmodule

// ----- design/cau_queue.sv -----
// short request queue between the front end and the arithmetic back end
module cau_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  cau_pkg::cau_op_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output cau_pkg::cau_op_t pop_data
);
    import cau_pkg::*;

    cau_op_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  push, pop;

    assign push_ready = count_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- design/cau_back.sv -----
// back end: multiply, sum, divide pipeline, saturation and output register
module cau_back #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_ready,
    input  cau_pkg::cau_op_t  op,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cau_pkg::cau_out_t rsp
);
    import cau_pkg::*;

    localparam int NW = 96 + 2 * FRAC_BITS;   // shifted dividend
    localparam int HW = NW - QBITS;

    logic adv;

    // multiply stage
    logic                    s1_valid_reg;
    logic signed [PRODW-1:0] prod_reg [MUL_SLOTS];
    logic                    s1_div_reg, s1_long_reg;
    logic signed [ADDW-1:0]  s1_add_re_reg, s1_add_im_reg;

    // sum stage
    logic                    s2_valid_reg;
    logic signed [SUMW-1:0]  num_re_reg, num_im_reg, den_sum_reg;
    logic                    s2_div_reg, s2_long_reg;
    logic signed [ADDW-1:0]  s2_add_re_reg, s2_add_im_reg;

    // divide stages, index 0 is the set-up stage
    logic [QBITS:0]          dv_reg;
    logic [DENW-1:0]         rem_re_reg [QBITS+1];
    logic [DENW-1:0]         rem_im_reg [QBITS+1];
    logic [QBITS-1:0]        lo_re_reg  [QBITS+1];
    logic [QBITS-1:0]        lo_im_reg  [QBITS+1];
    logic [QBITS-1:0]        q_re_reg   [QBITS+1];
    logic [QBITS-1:0]        q_im_reg   [QBITS+1];
    logic [DENW-1:0]         den_reg    [QBITS+1];
    cau_meta_t               meta_reg   [QBITS+1];

    logic                    rsp_valid_reg;
    cau_out_t                rsp_reg;

    assign adv       = !rsp_valid_reg || rsp_ready;
    assign op_ready  = adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            dv_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= op_valid;
            s2_valid_reg  <= s1_valid_reg;
            dv_reg        <= {dv_reg[QBITS-1:0], s2_valid_reg};
            rsp_valid_reg <= dv_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < MUL_SLOTS; i++)
                prod_reg[i] <= $signed(op.ma[i]) * $signed(op.mb[i]);
            s1_div_reg    <= op.is_div;
            s1_long_reg   <= op.long_shift;
            s1_add_re_reg <= op.add_re;
            s1_add_im_reg <= op.add_im;

            num_re_reg    <= SUMW'(prod_reg[0]) + SUMW'(prod_reg[1]);
            num_im_reg    <= SUMW'(prod_reg[2]) + SUMW'(prod_reg[3]);
            den_sum_reg   <= SUMW'(prod_reg[4]) + SUMW'(prod_reg[5]);
            s2_div_reg    <= s1_div_reg;
            s2_long_reg   <= s1_long_reg;
            s2_add_re_reg <= s1_add_re_reg;
            s2_add_im_reg <= s1_add_im_reg;
        end
    end

    // set-up: magnitudes, signs, scaled dividend, quotient cap check
    logic [SUMW-1:0]  an_re, an_im, an_den;
    logic [DENW-1:0]  n_re, n_im, d0;
    logic [NW-1:0]    big_re, big_im;
    logic [HW-1:0]    hi_re, hi_im;
    cau_meta_t        meta0;

    always_comb
    begin
        an_re  = num_re_reg[SUMW-1] ? SUMW'(-num_re_reg) : SUMW'(num_re_reg);
        an_im  = num_im_reg[SUMW-1] ? SUMW'(-num_im_reg) : SUMW'(num_im_reg);
        an_den = den_sum_reg[SUMW-1] ? SUMW'(-den_sum_reg) : SUMW'(den_sum_reg);
        n_re   = an_re[DENW-1:0];
        n_im   = an_im[DENW-1:0];
        d0     = an_den[DENW-1:0];
        big_re = s2_long_reg ? (NW'(n_re) << (2 * FRAC_BITS)) : (NW'(n_re) << FRAC_BITS);
        big_im = s2_long_reg ? (NW'(n_im) << (2 * FRAC_BITS)) : (NW'(n_im) << FRAC_BITS);
        hi_re  = big_re[NW-1:QBITS];
        hi_im  = big_im[NW-1:QBITS];

        meta0.is_div = s2_div_reg;
        meta0.divz   = s2_div_reg && (d0 == '0);
        meta0.neg_re = num_re_reg[SUMW-1] ^ den_sum_reg[SUMW-1];
        meta0.neg_im = num_im_reg[SUMW-1] ^ den_sum_reg[SUMW-1];
        meta0.ov_re  = hi_re >= HW'(d0);
        meta0.ov_im  = hi_im >= HW'(d0);
        // floor of the product sum plus the linear term
        meta0.lin_re = LW'(s2_add_re_reg) + LW'(num_re_reg >>> FRAC_BITS);
        meta0.lin_im = LW'(s2_add_im_reg) + LW'(num_im_reg >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_re_reg[0] <= hi_re[DENW-1:0];
            rem_im_reg[0] <= hi_im[DENW-1:0];
            lo_re_reg[0]  <= big_re[QBITS-1:0];
            lo_im_reg[0]  <= big_im[QBITS-1:0];
            q_re_reg[0]   <= '0;
            q_im_reg[0]   <= '0;
            den_reg[0]    <= d0;
            meta_reg[0]   <= meta0;
        end
    end

    // one restoring step per stage, quotient msb first
    for (genvar k = 0; k < QBITS; k++)
    begin : g_div
        logic [DENW:0] sh_re, sh_im;
        logic          ge_re, ge_im;

        assign sh_re = {rem_re_reg[k], lo_re_reg[k][QBITS-1-k]};
        assign sh_im = {rem_im_reg[k], lo_im_reg[k][QBITS-1-k]};
        assign ge_re = sh_re >= {1'b0, den_reg[k]};
        assign ge_im = sh_im >= {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_re_reg[k+1] <= ge_re ? DENW'(sh_re - {1'b0, den_reg[k]}) : sh_re[DENW-1:0];
                rem_im_reg[k+1] <= ge_im ? DENW'(sh_im - {1'b0, den_reg[k]}) : sh_im[DENW-1:0];
                lo_re_reg[k+1]  <= lo_re_reg[k];
                lo_im_reg[k+1]  <= lo_im_reg[k];
                q_re_reg[k+1]   <= {q_re_reg[k][QBITS-2:0], ge_re};
                q_im_reg[k+1]   <= {q_im_reg[k][QBITS-2:0], ge_im};
                den_reg[k+1]    <= den_reg[k];
                meta_reg[k+1]   <= meta_reg[k];
            end
        end
    end

    // sign, cap, saturation
    cau_meta_t            mf;
    logic [QBITS:0]       qc_re, qc_im;
    logic signed [LW-1:0] qv_re, qv_im, res_re, res_im;
    logic [32:0]          sat_re, sat_im;
    cau_out_t             rsp_next;

    always_comb
    begin
        mf     = meta_reg[QBITS];
        qc_re  = mf.ov_re ? {1'b1, QBITS'(0)} : {1'b0, q_re_reg[QBITS]};
        qc_im  = mf.ov_im ? {1'b1, QBITS'(0)} : {1'b0, q_im_reg[QBITS]};
        qv_re  = mf.neg_re ? -LW'(qc_re) : LW'(qc_re);
        qv_im  = mf.neg_im ? -LW'(qc_im) : LW'(qc_im);
        res_re = mf.is_div ? qv_re : mf.lin_re;
        res_im = mf.is_div ? qv_im : mf.lin_im;
        sat_re = sat32(res_re);
        sat_im = sat32(res_im);
        if (mf.divz)
        begin
            rsp_next.r_re   = '0;
            rsp_next.r_im   = '0;
            rsp_next.status = ST_DIVZ;
        end
        else
        begin
            rsp_next.r_re   = sat_re[31:0];
            rsp_next.r_im   = sat_im[31:0];
            rsp_next.status = (sat_re[32] || sat_im[32]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    a_pop_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_ready |=> s1_valid_reg)
        else $error("popped request did not enter the multiply stage");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_DIVZ |-> rsp_reg.r_re == '0 && rsp_reg.r_im == '0)
        else $error("division by zero result is not zero");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_SAT |->
            rsp_reg.r_re == SAT_HI[31:0] || rsp_reg.r_re == SAT_LO[31:0] ||
            rsp_reg.r_im == SAT_HI[31:0] || rsp_reg.r_im == SAT_LO[31:0])
        else $error("saturated status without a clamped part");

    a_divz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[QBITS] && meta_reg[QBITS].divz |-> meta_reg[QBITS].is_div)
        else $error("zero divisor flagged on a non-dividing operation");

endmodule

// ----- design/complex_arith_unit.sv -----
// complex arithmetic unit top level: front end, request queue and back end
//
// requests come in on req (req_valid/req_ready), one complex result leaves on
// rsp (rsp_valid/rsp_ready) for every request, in order.
// the front end decodes the operation as a request is taken and writes it to
// a two-entry queue; the back end takes one request from the queue per cycle
// while the output does not stall it. on its way to rsp_valid a request
// passes the queue entry, multiply, product sum, divider set-up, 32 restoring
// divider stages (one quotient bit each) and the output register. every
// operation takes the same path, so results leave in order with no gaps.
// throughput is one request per cycle, sustained, for all sixteen operations,
// unless the output stalls. when rsp_ready is low while a result waits, the
// whole back end holds; the queue takes at most two more and req_ready falls.
// reset empties the queue and clears every stage valid; no result is pending
// after reset and there is nothing else to initialise.
module complex_arith_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cau_pkg::cau_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cau_pkg::cau_out_t rsp
);
    import cau_pkg::*;

    cau_op_t front_op;
    cau_op_t queue_op;
    logic    queue_valid;
    logic    back_ready;

    cau_front u_front (
        .req (req),
        .op  (front_op)
    );

    cau_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid),
        .push_ready (req_ready),
        .push_data  (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (back_ready),
        .pop_data   (queue_op)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (queue_valid),
        .op_ready  (back_ready),
        .op        (queue_op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- verif/cau_checker.sv -----
// result predictor and in-order comparator for the complex arithmetic unit
`timescale 1ns / 100ps

module cau_checker
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  cau_in_t  req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  cau_out_t rsp,
    output int       fail_count,
    output int       pending
);

    localparam int FRAC = FRAC_BITS_DEFAULT;
    localparam logic signed [127:0] QCAP = 128'sd1 <<< 32;

    cau_out_t expected_results[$];

    // floor of an exact product sum to FRAC fraction bits
    function automatic logic signed [127:0] floor_q(input logic signed [127:0] x);
        return x >>> FRAC;
    endfunction

    // quotient truncated toward zero, magnitude capped at 2^32
    function automatic logic signed [127:0] trunc_quot(input logic signed [127:0] n,
                                                       input logic dneg,
                                                       input logic signed [127:0] d,
                                                       input int steps);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (n < 0) ? -n : n;
        q = (mag <<< steps) / d;
        if (q > QCAP)
            q = QCAP;
        return ((n < 0) != dneg) ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x,
                                                   inout logic hit);
        if (x > 128'sd2147483647) begin
            hit = 1'b1;
            return 32'h7fffffff;
        end
        if (x < -128'sd2147483648) begin
            hit = 1'b1;
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    function automatic cau_out_t compute_complex_result(input cau_in_t r);
        logic signed [127:0] ar, ai, br, bi, s, re, im, den;
        logic divz;
        logic hit;
        cau_out_t o;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        s = r.scalar;
        re = 0;
        im = 0;
        divz = 1'b0;
        hit = 1'b0;
        case (r.kind)
            OP_ADD:     begin re = ar + br; im = ai + bi; end
            OP_SUB:     begin re = ar - br; im = ai - bi; end
            OP_MUL:
            begin
                re = floor_q(ar * br - ai * bi);
                im = floor_q(ar * bi + ai * br);
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    divz = 1'b1;
                else
                begin
                    re = trunc_quot(ar * br + ai * bi, 1'b0, den, FRAC);
                    im = trunc_quot(br * ai - ar * bi, 1'b0, den, FRAC);
                end
            end
            OP_MULCONJ:
            begin
                re = floor_q(ar * br + ai * bi);
                im = floor_q(ai * br - ar * bi);
            end
            OP_CONJ:    begin re = ar; im = -ai; end
            OP_NEG:     begin re = -ar; im = -ai; end
            OP_INV:
            begin
                den = ar * ar + ai * ai;
                if (den == 0)
                    divz = 1'b1;
                else
                begin
                    re = trunc_quot(ar, 1'b0, den, 2 * FRAC);
                    im = trunc_quot(-ai, 1'b0, den, 2 * FRAC);
                end
            end
            OP_ADDS:    begin re = ar + s; im = ai; end
            OP_SUBS:    begin re = ar - s; im = ai; end
            OP_MULS:
            begin
                re = floor_q(ar * s);
                im = floor_q(ai * s);
            end
            OP_DIVS:
            begin
                if (s == 0)
                    divz = 1'b1;
                else
                begin
                    den = (s < 0) ? -s : s;
                    re = trunc_quot(ar, s < 0, den, FRAC);
                    im = trunc_quot(ai, s < 0, den, FRAC);
                end
            end
            OP_RSUB:    begin re = s - ar; im = -ai; end
            OP_RDIV:
            begin
                den = ar * ar + ai * ai;
                if (den == 0)
                    divz = 1'b1;
                else
                begin
                    re = trunc_quot(s * ar, 1'b0, den, FRAC);
                    im = trunc_quot(-(s * ai), 1'b0, den, FRAC);
                end
            end
            OP_MIX:
            begin
                re = ar + floor_q((br - ar) * s);
                im = ai + floor_q((bi - ai) * s);
            end
            default:
            begin
                re = floor_q(ar * ar + ai * ai);
                im = 0;
            end
        endcase
        if (divz)
        begin
            o.r_re = '0;
            o.r_im = '0;
            o.status = ST_DIVZ;
        end
        else
        begin
            o.r_re = clamp32(re, hit);
            o.r_im = clamp32(im, hit);
            o.status = hit ? ST_SAT : ST_OK;
        end
        return o;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        cau_out_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            fail_count <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_results.push_back(compute_complex_result(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result re=%0d im=%0d status=%0d",
                           rsp.r_re, rsp.r_im, rsp.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.r_re !== want.r_re)
                        $error("r_re expected %0d got %0d", want.r_re, rsp.r_re);
                    if (rsp.r_im !== want.r_im)
                        $error("r_im expected %0d got %0d", want.r_im, rsp.r_im);
                    if (rsp.status !== want.status)
                        $error("status expected %0d got %0d", want.status, rsp.status);
                    if (rsp !== want)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

// ----- verif/tb.sv -----
// stimulus and verdict for the complex arithmetic unit
`timescale 1ns / 100ps

module tb;
    import cau_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    cau_in_t  req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    cau_out_t rsp;
    int       fail_count;
    int       pending;
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    int       hold_cycles = 0;

    localparam logic [31:0] QMAX = 32'h7fffffff;
    localparam logic [31:0] QMIN = 32'h80000000;
    localparam logic [31:0] QONE = 32'h00010000;

    always #1 clk = ~clk;

    complex_arith_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    cau_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: random stalls, or a long hold-off while hold_cycles runs down
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send_request(input cau_kind_t k, input logic [31:0] ar,
                                input logic [31:0] ai, input logic [31:0] br,
                                input logic [31:0] bi, input logic [31:0] s);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req = '{kind: k, a_re: ar, a_im: ai, b_re: br, b_im: bi, scalar: s};
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return QMIN;
            2: return QMAX;
            3: return QONE * ($urandom_range(15) - 7);
            4, 5: return $urandom_range(32'h1fffff) - 32'h100000;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(cau_kind_t'($urandom_range(15)), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand(), pick_operand());
        drop_valid();
    endtask

    task automatic drain();
        wait (pending == 0);
    endtask

    initial
    begin
        #200000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one of each operation, then the edge cases
        for (int k = 0; k < 16; k++)
            send_request(cau_kind_t'(k), 32'h00018000, 32'hfffe4000,
                         32'h00030000, 32'h00008000, 32'h00024000);
        send_request(OP_ADD, QMAX, QMIN, QMAX, QMIN, 0);
        send_request(OP_NEG, QMIN, QMIN, 0, 0, 0);
        send_request(OP_DIV, QONE, QONE, 0, 0, 0);
        send_request(OP_INV, 0, 0, QONE, QONE, QONE);
        send_request(OP_DIVS, QMAX, QMIN, QONE, QONE, 0);
        send_request(OP_RDIV, 0, 0, QONE, QONE, QONE);
        send_request(OP_MUL, QMIN, QMIN, QMIN, QMIN, QMIN);
        send_request(OP_NORMSQ, QMIN, QMAX, 0, 0, 0);
        send_request(OP_INV, 32'd1, 32'd0, 0, 0, 0);
        send_request(OP_MIX, QMIN, QMAX, QMAX, QMIN, QMIN);
        drop_valid();
        drain();

        send_random(165);
        drain();
        sender_idle_pct = 53;
        send_random(165);
        drain();
        sender_idle_pct = 0;
        receiver_stall_pct = 53;
        send_random(165);
        drain();
        sender_idle_pct = 38;
        receiver_stall_pct = 38;
        send_random(165);
        drain();

        // long receiver hold-off so the queue fills and requests back up
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        @(negedge clk);
        hold_cycles = 80;
        send_random(40);
        drain();

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
